// File: sv/dtok_pkg.sv
package dtok_pkg;

  // Longest string tracked before the byte position saturates
  localparam int unsigned MaxStringLen = 65536;
  localparam int unsigned PosW         = $clog2(MaxStringLen) + 1;
  localparam int unsigned StartW       = 16;
  localparam int unsigned LenW         = 17;
  localparam int unsigned IndexW       = 16;

  localparam logic [PosW-1:0]   PosLimit   = PosW'(MaxStringLen);
  localparam logic [PosW-1:0]   PosLast    = PosW'(MaxStringLen - 1);
  localparam logic [IndexW-1:0] IndexLimit = '1;

  // Configuration port
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgDelimiterMode   = 2'd0,
    CfgKeepEmptyTokens = 2'd1,
    CfgUnused2         = 2'd2,
    CfgUnused3         = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    DelimZeroOnly   = 2'd0,
    DelimNewline    = 2'd1,
    DelimSpace      = 2'd2,
    DelimSpaceComma = 2'd3
  } delim_mode_e;

  // Character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic              token_valid;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic [IndexW-1:0] token_index;
    logic              string_end;
    logic              position_overflow;
  } out_word_t;

endpackage

// File: sv/delimiter_tokenizer_unit.sv
// Delimiter tokenizer: takes one byte of a string per word and returns one result word per
// byte in the next cycle, at one byte per cycle while not stalled. The result says whether
// the byte closes a token and, if so, gives the token's start offset, length and ordinal
// within the string. A zero byte always delimits; delimiter_mode adds newline, whitespace
// or whitespace and comma. Zero-length tokens between adjacent delimiters appear only with
// keep_empty_tokens set; a non-empty final segment is reported on the end-of-string byte.
// Positions saturate after 65536 bytes and raise a sticky overflow flag, cleared only by
// reset. The result is held in the single result register; the input side
// stalls only while that register holds a word the consumer has not taken. Write the
// configuration only while the block is idle.
module delimiter_tokenizer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // byte input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  dtok_pkg::in_word_t                    in_word_i,
  // token output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output dtok_pkg::out_word_t                   out_word_o,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [dtok_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [dtok_pkg::CfgDataW-1:0]         cfg_data_i
);

  // Configuration registers
  dtok_pkg::delim_mode_e delim_mode_q;
  logic                  keep_empty_q;

  // String state
  logic [dtok_pkg::PosW-1:0]   byte_pos_q,   byte_pos_d;
  logic [dtok_pkg::PosW-1:0]   seg_start_q,  seg_start_d;
  logic [dtok_pkg::IndexW-1:0] tok_count_q,  tok_count_d;
  logic                        overflow_q,   overflow_d;

  // Result register
  logic                out_valid_q;
  dtok_pkg::out_word_t out_word_q, out_word_d;

  logic                      in_accept;
  logic                      pos_full;
  logic [dtok_pkg::PosW-1:0] pos_eff;
  logic [dtok_pkg::PosW-1:0] pos_next;
  logic                      is_space;
  logic                      is_delim;
  logic [dtok_pkg::PosW-1:0] tok_len;
  logic                      emit;
  logic [dtok_pkg::PosW-1:0] start_sat;

  // Stall the input only while a finished word waits on a stalled consumer
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Delimiter classification
  always_comb begin
    is_space = (in_word_i.byte_value == dtok_pkg::ChSpace) ||
               (in_word_i.byte_value == dtok_pkg::ChTab)   ||
               (in_word_i.byte_value == dtok_pkg::ChLf)    ||
               (in_word_i.byte_value == dtok_pkg::ChVt)    ||
               (in_word_i.byte_value == dtok_pkg::ChFf)    ||
               (in_word_i.byte_value == dtok_pkg::ChCr);
    is_delim = 1'b0;
    unique case (delim_mode_q)
      dtok_pkg::DelimZeroOnly:   is_delim = 1'b0;
      dtok_pkg::DelimNewline:    is_delim = (in_word_i.byte_value == dtok_pkg::ChLf);
      dtok_pkg::DelimSpace:      is_delim = is_space;
      dtok_pkg::DelimSpaceComma: is_delim = is_space ||
                                            (in_word_i.byte_value == dtok_pkg::ChComma);
      default:                   is_delim = 1'b0;
    endcase
    if (in_word_i.byte_value == dtok_pkg::ChNul) begin
      is_delim = 1'b1;
    end
  end

  // Token arithmetic for the byte at the input
  always_comb begin
    // Saturate: a byte past the limit sits at the last offset
    pos_full   = (byte_pos_q >= dtok_pkg::PosLimit);
    pos_eff    = pos_full ? dtok_pkg::PosLast : byte_pos_q;
    pos_next   = pos_eff + dtok_pkg::PosW'(1);
    overflow_d = overflow_q | pos_full;
    byte_pos_d = pos_full ? byte_pos_q : pos_next;

    seg_start_d = seg_start_q;
    tok_len     = '0;
    emit        = 1'b0;
    if (is_delim) begin
      tok_len     = (pos_eff >= seg_start_q) ? pos_eff - seg_start_q : '0;
      emit        = keep_empty_q || (tok_len != '0);
      seg_start_d = pos_next;
    end else if (in_word_i.end_of_string) begin
      tok_len = (pos_next >= seg_start_q) ? pos_next - seg_start_q : '0;
      emit    = (tok_len != '0);
    end

    start_sat = (seg_start_q > dtok_pkg::PosLast) ? dtok_pkg::PosLast : seg_start_q;

    out_word_d.token_valid       = emit;
    out_word_d.token_start       = emit ? start_sat[dtok_pkg::StartW-1:0] : '0;
    out_word_d.token_length      = emit ? dtok_pkg::LenW'(tok_len) : '0;
    out_word_d.token_index       = emit ? tok_count_q : '0;
    out_word_d.string_end        = in_word_i.end_of_string;
    out_word_d.position_overflow = overflow_d;

    tok_count_d = tok_count_q;
    if (emit && (tok_count_q != dtok_pkg::IndexLimit)) begin
      tok_count_d = tok_count_q + dtok_pkg::IndexW'(1);
    end

    // Drop all per-string state at the end of the string
    if (in_word_i.end_of_string) begin
      byte_pos_d  = '0;
      seg_start_d = '0;
      tok_count_d = '0;
    end
  end

  // Configuration and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_mode_q <= dtok_pkg::DelimSpace;
      keep_empty_q <= 1'b0;
      byte_pos_q   <= '0;
      seg_start_q  <= '0;
      tok_count_q  <= '0;
      overflow_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dtok_pkg::cfg_index_e'(cfg_index_i))
          dtok_pkg::CfgDelimiterMode:   delim_mode_q <= dtok_pkg::delim_mode_e'(cfg_data_i[1:0]);
          dtok_pkg::CfgKeepEmptyTokens: keep_empty_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_accept) begin
        byte_pos_q  <= byte_pos_d;
        seg_start_q <= seg_start_d;
        tok_count_q <= tok_count_d;
        overflow_q  <= overflow_d;
      end
    end
  end

  // Result register: advance on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// File: dv/tb_delimiter_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_delimiter_tokenizer_unit;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  dtok_pkg::in_word_t            in_word   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dtok_pkg::out_word_t           out_word;
  logic                          cfg_we    = 1'b0;
  dtok_pkg::cfg_index_e          cfg_index = dtok_pkg::CfgDelimiterMode;
  logic [dtok_pkg::CfgDataW-1:0] cfg_data  = '0;

  // Shadow of the tokenizer: configuration and per-string state
  dtok_pkg::delim_mode_e         cfg_mode  = dtok_pkg::DelimSpace;
  logic                          cfg_keep  = 1'b0;
  logic [dtok_pkg::PosW-1:0]     str_pos   = '0;
  logic [dtok_pkg::PosW-1:0]     seg_start = '0;
  logic [dtok_pkg::IndexW-1:0]   tok_count = '0;
  logic                          ovf_flag  = 1'b0;

  dtok_pkg::out_word_t  expected_tokens[$];
  int unsigned          failures      = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          hold_cycles   = 0;

  delimiter_tokenizer_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall at random, or hold off for a counted stretch when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Zero always splits; the mode adds newline, whitespace, or whitespace and comma
  function automatic logic is_break(logic [7:0] c);
    logic space;
    space = c inside {dtok_pkg::ChSpace, dtok_pkg::ChTab, dtok_pkg::ChLf,
                      dtok_pkg::ChVt, dtok_pkg::ChFf, dtok_pkg::ChCr};
    if (c == dtok_pkg::ChNul) return 1'b1;
    case (cfg_mode)
      dtok_pkg::DelimNewline:    return c == dtok_pkg::ChLf;
      dtok_pkg::DelimSpace:      return space;
      dtok_pkg::DelimSpaceComma: return space || (c == dtok_pkg::ChComma);
      default:                   return 1'b0;
    endcase
  endfunction

  // Advance the shadow state by one byte and return the result word it yields
  function automatic dtok_pkg::out_word_t predict_token(dtok_pkg::in_word_t w);
    logic [dtok_pkg::PosW-1:0] p;
    logic [dtok_pkg::PosW-1:0] p_next;
    logic [dtok_pkg::PosW-1:0] start;
    logic [dtok_pkg::PosW-1:0] len;
    logic                      emit;
    dtok_pkg::out_word_t       r;
    p     = str_pos;
    start = seg_start;
    len   = '0;
    emit  = 1'b0;
    // Saturate the position once the string runs past its limit
    if (str_pos >= dtok_pkg::PosLimit) begin
      ovf_flag = 1'b1;
      p = dtok_pkg::PosLast;
    end else begin
      str_pos = str_pos + dtok_pkg::PosW'(1);
    end
    p_next = p + dtok_pkg::PosW'(1);
    if (is_break(w.byte_value)) begin
      len       = (p >= start) ? p - start : '0;
      emit      = cfg_keep || (len != '0);
      seg_start = p_next;
    end else if (w.end_of_string) begin
      // Close a non-empty tail on the last byte
      len  = (p_next >= start) ? p_next - start : '0;
      emit = (len != '0);
    end
    if (start > dtok_pkg::PosLast) start = dtok_pkg::PosLast;
    r = '0;
    if (emit) begin
      r.token_valid  = 1'b1;
      r.token_start  = start[dtok_pkg::StartW-1:0];
      r.token_length = len[dtok_pkg::LenW-1:0];
      r.token_index  = tok_count;
    end
    r.string_end        = w.end_of_string;
    r.position_overflow = ovf_flag;
    if (emit && tok_count != dtok_pkg::IndexLimit) begin
      tok_count = tok_count + dtok_pkg::IndexW'(1);
    end
    if (w.end_of_string) begin
      str_pos   = '0;
      seg_start = '0;
      tok_count = '0;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      failures++;
      $error("%s: expected %0d, got %0d", name, want, seen);
    end
  endtask

  // Checker: capture a word that will be taken at the next edge, then match it
  initial begin
    dtok_pkg::out_word_t got;
    dtok_pkg::out_word_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        got = out_word;
        @(posedge clk);
        if (expected_tokens.size() == 0) begin
          failures++;
          $error("result word with nothing expected");
        end else begin
          want = expected_tokens.pop_front();
          compare_field("token_valid", 32'(want.token_valid), 32'(got.token_valid));
          compare_field("token_start", 32'(want.token_start), 32'(got.token_start));
          compare_field("token_length", 32'(want.token_length),
                        32'(got.token_length));
          compare_field("token_index", 32'(want.token_index), 32'(got.token_index));
          compare_field("string_end", 32'(want.string_end), 32'(got.string_end));
          compare_field("position_overflow", 32'(want.position_overflow),
                        32'(got.position_overflow));
        end
      end
    end
  end

  // Offer one byte, idling first at random; return at the edge that takes it.
  // Valid is left high so a following call drives the next word in the same step.
  task automatic send_byte(logic [7:0] b, logic eos);
    dtok_pkg::in_word_t w;
    w.byte_value    = b;
    w.end_of_string = eos;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
    end while (in_stall);
    // Stall is low and steady until the edge: the word is taken there
    expected_tokens.push_back(predict_token(w));
    @(posedge clk);
  endtask

  // Drop valid and let the block drain before touching a register
  task automatic write_reg(dtok_pkg::cfg_index_e idx, logic [dtok_pkg::CfgDataW-1:0] data);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dtok_pkg::CfgDelimiterMode:   cfg_mode = dtok_pkg::delim_mode_e'(data);
      dtok_pkg::CfgKeepEmptyTokens: cfg_keep = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] delim_char(int unsigned k);
    case (k)
      0:       return dtok_pkg::ChNul;
      1:       return dtok_pkg::ChTab;
      2:       return dtok_pkg::ChLf;
      3:       return dtok_pkg::ChVt;
      4:       return dtok_pkg::ChFf;
      5:       return dtok_pkg::ChCr;
      6:       return dtok_pkg::ChSpace;
      default: return dtok_pkg::ChComma;
    endcase
  endfunction

  // Mostly letters, a heavy share of delimiters, some arbitrary bytes
  function automatic logic [7:0] random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return delim_char($urandom_range(7));
    if (pick < 50) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7A, 8'h61));
  endfunction

  // Reset values: whitespace splits, empty tokens are dropped
  task automatic test_reset_defaults();
    send_byte(8'h61, 1'b0);
    send_byte(dtok_pkg::ChTab, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(dtok_pkg::ChVt, 1'b0);
    send_byte(dtok_pkg::ChFf, 1'b0);
    send_byte(dtok_pkg::ChCr, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Same string under every delimiter class, empty tokens on and off;
  // ends on a zero byte right after a tab to give an empty tail
  task automatic test_delimiter_modes();
    for (int m = 0; m < 4; m++) begin
      write_reg(dtok_pkg::CfgDelimiterMode, dtok_pkg::CfgDataW'(m));
      write_reg(dtok_pkg::CfgKeepEmptyTokens, dtok_pkg::CfgDataW'(~m[0]));
      send_byte(dtok_pkg::ChComma, 1'b0);
      send_byte(dtok_pkg::ChLf, 1'b0);
      send_byte(dtok_pkg::ChSpace, 1'b0);
      send_byte(8'h7A, 1'b0);
      send_byte(dtok_pkg::ChTab, 1'b0);
      send_byte(dtok_pkg::ChNul, 1'b1);
    end
  endtask

  // Writes to indexes with no register behind them must change nothing
  task automatic test_unused_registers();
    write_reg(dtok_pkg::CfgUnused2, '1);
    write_reg(dtok_pkg::CfgUnused3, '1);
    send_byte(8'h71, 1'b0);
    send_byte(dtok_pkg::ChSpace, 1'b0);
    send_byte(8'h72, 1'b1);
  endtask

  // Well-formed strings of random content, with some stray noise bytes
  task automatic test_random_strings(int unsigned target);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        sent++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) send_byte(random_char(), i == len - 1);
        sent += len;
      end
    end
  endtask

  // Several configurations per phase, extremes in the first phase
  task automatic test_random_phase(logic first);
    for (int s = 0; s < 4; s++) begin
      if (first && s == 0) begin
        write_reg(dtok_pkg::CfgDelimiterMode, dtok_pkg::CfgDataW'(dtok_pkg::DelimZeroOnly));
        write_reg(dtok_pkg::CfgKeepEmptyTokens, '0);
      end else if (first && s == 1) begin
        write_reg(dtok_pkg::CfgDelimiterMode,
                  dtok_pkg::CfgDataW'(dtok_pkg::DelimSpaceComma));
        write_reg(dtok_pkg::CfgKeepEmptyTokens, '1);
      end else begin
        write_reg(dtok_pkg::CfgDelimiterMode, dtok_pkg::CfgDataW'($urandom_range(3)));
        write_reg(dtok_pkg::CfgKeepEmptyTokens, dtok_pkg::CfgDataW'($urandom_range(3)));
      end
      test_random_strings(125);
    end
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_byte(random_char(), i == 39);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 76;
    test_reset_defaults();
    test_delimiter_modes();
    test_unused_registers();
    test_random_phase(1'b1);

    // Swap the idling
    send_idle_pct = 76;
    recv_idle_pct = 28;
    test_random_phase(1'b0);

    // Full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(1'b0);
    test_backpressure();

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
